/* hw/rtl/byte_alu_with_flags_top_macros.svh */
// Assertion macros for the byte ALU.
`ifndef BYTE_ALU_WITH_FLAGS_TOP_MACROS_SVH
`define BYTE_ALU_WITH_FLAGS_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define BAWF_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define BAWF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define BAWF_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define BAWF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

/* hw/rtl/bawf_pkg.sv */
`timescale 1ns / 1ps
package bawf_pkg;

    localparam int unsigned ByteW = 8;
    localparam int unsigned KindW = 4;

    typedef enum logic [KindW-1:0] {
        OP_ADD   = 4'd0,
        OP_SUB   = 4'd1,
        OP_SHL   = 4'd2,
        OP_SHR   = 4'd3,
        OP_INC_A = 4'd4,
        OP_DEC_A = 4'd5,
        OP_INC_B = 4'd6,
        OP_DEC_B = 4'd7,
        OP_AND   = 4'd8,
        OP_OR    = 4'd9,
        OP_XOR   = 4'd10,
        OP_NOT_A = 4'd11,
        OP_NOT_B = 4'd12
    } t_alu_op;

    typedef struct packed {
        logic [ByteW-1:0] operand_a;
        logic [ByteW-1:0] operand_b;
        logic [KindW-1:0] kind;
        logic             clear_flags;
        logic             drive_enable;
    } t_alu_req;

    typedef struct packed {
        logic [ByteW-1:0] result_byte;
        logic             carry;
        logic             overflow;
        logic             extra_carry;
        logic             sign;
        logic             zero;
    } t_alu_state;

endpackage

/* hw/rtl/bawf_alu.sv */
`timescale 1ns / 1ps
module bawf_alu (
    input  bawf_pkg::t_alu_req   i_req,
    input  bawf_pkg::t_alu_state i_state,
    output bawf_pkg::t_alu_state o_state
);
    import bawf_pkg::*;

    logic       cin;
    logic       carry_clr;
    logic       ovf_clr;
    logic       ext_clr;
    logic [9:0] wide;
    logic [9:0] a_ext;
    logic [9:0] b_ext;
    logic       out_of_signed;
    logic       force_sign;
    t_alu_state nxt;

    assign carry_clr = i_state.carry & ~i_req.clear_flags;
    assign ovf_clr   = i_state.overflow & ~i_req.clear_flags;
    assign ext_clr   = i_state.extra_carry & ~i_req.clear_flags;
    assign cin       = i_req.drive_enable & carry_clr;
    assign a_ext     = {2'b00, i_req.operand_a};
    assign b_ext     = {2'b00, i_req.operand_b};

    always_comb begin
        nxt             = i_state;
        nxt.carry       = carry_clr;
        nxt.overflow    = ovf_clr;
        nxt.extra_carry = ext_clr;
        force_sign      = 1'b0;
        wide            = '0;
        out_of_signed   = 1'b0;
        case (t_alu_op'(i_req.kind))
            OP_ADD, OP_SUB: begin
                if (t_alu_op'(i_req.kind) == OP_ADD) begin
                    wide = a_ext + b_ext + {9'd0, cin};
                end else begin
                    wide = a_ext - b_ext - {9'd0, cin};
                end
                out_of_signed = ($signed(wide) > 10'sd127) || ($signed(wide) < -10'sd127);
                if (i_req.drive_enable) begin
                    nxt.overflow = out_of_signed;
                    if (t_alu_op'(i_req.kind) == OP_ADD) begin
                        nxt.carry = $signed(wide) > 10'sd255;
                    end else begin
                        nxt.carry = wide[9];
                    end
                    nxt.extra_carry = ~((~i_req.operand_b[7] & ~($signed(wide) > 10'sd255)) |
                                        (i_req.operand_b[7] & ($signed(wide) > 10'sd255)));
                    if (nxt.extra_carry) begin
                        force_sign = 1'b1;
                        nxt.sign   = i_req.operand_b[7];
                    end
                end
                nxt.result_byte = wide[7:0];
            end
            OP_SHL: begin
                nxt.result_byte = {i_req.operand_a[6:0], 1'b0};
                nxt.carry       = i_req.operand_a[7];
            end
            OP_SHR: begin
                nxt.result_byte = {1'b0, i_req.operand_a[7:1]};
                nxt.carry       = 1'b0;
            end
            OP_INC_A, OP_DEC_A, OP_INC_B, OP_DEC_B: begin
                if (i_req.kind[0]) begin
                    wide = (i_req.kind[1] ? b_ext : a_ext) - 10'd1;
                end else begin
                    wide = (i_req.kind[1] ? b_ext : a_ext) + 10'd1;
                end
                out_of_signed = ($signed(wide) > 10'sd127) || ($signed(wide) < -10'sd127);
                nxt.result_byte = wide[7:0];
                if (i_req.drive_enable) begin
                    nxt.overflow = out_of_signed;
                    nxt.carry    = i_req.kind[0] ? wide[9] : ($signed(wide) > 10'sd255);
                end
            end
            OP_AND:   nxt.result_byte = i_req.operand_a & i_req.operand_b;
            OP_OR:    nxt.result_byte = i_req.operand_a | i_req.operand_b;
            OP_XOR:   nxt.result_byte = i_req.operand_a ^ i_req.operand_b;
            OP_NOT_A: nxt.result_byte = ~i_req.operand_a;
            OP_NOT_B: nxt.result_byte = ~i_req.operand_b;
            default: begin
                nxt.result_byte = i_state.result_byte;
            end
        endcase
        if (i_req.drive_enable) begin
            nxt.zero = (nxt.result_byte == 8'd0);
            if (!force_sign) begin
                nxt.sign = nxt.result_byte[7];
            end
        end
    end

    assign o_state = nxt;

endmodule

/* hw/rtl/byte_alu_with_flags_top.sv */
`timescale 1ns / 1ps
// Byte ALU with a flag register. One request per cycle is accepted unless a
// stalled output holds the input register; each gives exactly one result through
// the input register, then the ALU and flag update feeding the result register,
// and back-to-back requests see the flags left by the one before. Codes 13 to 15
// keep the last result byte. When drive_enable is low the result field carries
// zero but the stored byte and the shift carry still update. Full throughput is
// held while the output side takes a result every cycle.
`include "byte_alu_with_flags_top_macros.svh"
module byte_alu_with_flags_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // operand_a[7:0], operand_b[15:8], clear_flags[16], drive_enable[17], zero[23:18]
    input  logic [23:0] s_tdata,
    // kind[3:0]
    input  logic [3:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // bus_value[7:0], bus_driven[8], carry_out[9], overflow_out[10],
    // extra_carry_out[11], sign_out[12], zero_out[13], zero[15:14]
    output logic [15:0] m_tdata
);
    import bawf_pkg::*;

    logic       r_s1_valid;
    t_alu_req   r_s1_req;
    t_alu_state r_state;
    t_alu_state n_state;
    logic       r_m_valid;
    logic [15:0] r_m_data;
    logic       out_ready;
    logic       s1_adv;

    assign out_ready = ~r_m_valid | m_tready;
    assign s1_adv    = r_s1_valid & out_ready;
    assign s_tready  = ~r_s1_valid | out_ready;

    bawf_alu u_alu (
        .i_req   (r_s1_req),
        .i_state (r_state),
        .o_state (n_state)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_m_valid  <= 1'b0;
            r_state    <= '0;
        end else begin
            if (s_tready) begin
                r_s1_valid <= s_tvalid;
            end
            if (out_ready) begin
                r_m_valid <= r_s1_valid;
            end
            if (s1_adv) begin
                r_state <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_tvalid && s_tready) begin
            r_s1_req.operand_a    <= s_tdata[7:0];
            r_s1_req.operand_b    <= s_tdata[15:8];
            r_s1_req.kind         <= s_tuser;
            r_s1_req.clear_flags  <= s_tdata[16];
            r_s1_req.drive_enable <= s_tdata[17];
        end
        if (s1_adv) begin
            r_m_data <= {2'b00, n_state.zero, n_state.sign, n_state.extra_carry,
                         n_state.overflow, n_state.carry, r_s1_req.drive_enable,
                         r_s1_req.drive_enable ? n_state.result_byte : 8'd0};
        end
    end

    assign m_tvalid = r_m_valid;
    assign m_tdata  = r_m_data;

    `BAWF_ASSERT_IMPL(a_zero_flag, i_clk, i_rst_n, r_m_valid && r_m_data[8], r_m_data[13] == (r_m_data[7:0] == 8'd0), "zero flag disagrees with driven byte")
    `BAWF_ASSERT_IMPL(a_undriven_bus, i_clk, i_rst_n, r_m_valid && !r_m_data[8], r_m_data[7:0] == 8'd0, "undriven result not zero")
    `BAWF_ASSERT_NEXT(a_s1_hold, i_clk, i_rst_n, r_s1_valid && !out_ready, r_s1_valid && $stable(r_state), "stage one lost a request or state moved while stalled")
    `BAWF_ASSERT_NEXT(a_out_fill, i_clk, i_rst_n, s1_adv, r_m_valid, "advanced request missing at output")

endmodule
